[rtl/lidar_point_camera_projection_defines.svh]
// Assertion macros for the lidar point camera projection block.
// Used by files that check their own logic; expects clk and rst in scope.
`ifndef LIDAR_POINT_CAMERA_PROJECTION_DEFINES_SVH
`define LIDAR_POINT_CAMERA_PROJECTION_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPCP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lpcp_pkg.sv]
// Shared widths, types and register codes for the lidar point projection block.
// No dependencies; used by the interfaces, the divider lane and the top level.
`default_nettype none

package lpcp_pkg;

  // Field widths
  localparam int PT_W        = 24;  // Q7.16 point coordinate
  localparam int ROT_W       = 16;  // Q2.14 rotation entry
  localparam int OFF_W       = 20;  // Q3.16 translation entry
  localparam int FOC_W       = 20;  // Q12.8 focal length / center
  localparam int PIX_W       = 24;  // Q15.8 pixel coordinate
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 60;
  localparam int ROW_W       = 3 * ROT_W;
  localparam int TRANS_W     = 3 * OFF_W;
  localparam int PAIR_W      = 2 * FOC_W;

  // Datapath widths
  localparam int PROD_W      = ROT_W + PT_W;       // one rotation product
  localparam int SUM_W       = PROD_W + 1;         // sum of three products
  localparam int FRAC_SHIFT  = 14;                 // Q30 -> Q16
  localparam int CAM_W       = 27;                 // camera coordinate, Q16
  localparam int NUM_W       = FOC_W + CAM_W;      // f * coordinate, signed
  localparam int MAG_W       = NUM_W - 1;          // its magnitude
  localparam int DEN_W       = CAM_W - 1;          // positive depth
  localparam int QB          = 25;                 // quotient bits kept
  localparam int RES_W       = QB + 2;             // signed +/-q + c
  localparam int DIV_LAT     = QB + 1;             // prep stage + one per bit

  localparam logic signed [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};
  localparam logic signed [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W-1){1'b0}}};

  // Configuration register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_ROW0  = 3'd0,
    REG_ROT_ROW1  = 3'd1,
    REG_ROT_ROW2  = 3'd2,
    REG_TRANS     = 3'd3,
    REG_FOCAL     = 3'd4,
    REG_PRINCIPAL = 3'd5
  } cfg_idx_t;

  // Request into one projection lane
  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
    logic [FOC_W-1:0]        c;
  } lane_req_t;

  // Result out of one projection lane
  typedef struct packed {
    logic signed [PIX_W-1:0] pix;
    logic                    clip;
  } lane_res_t;

  // One finished result item
  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_u;
    logic signed [PIX_W-1:0] pixel_v;
    logic                    in_front;
    logic                    clipped;
  } pix_item_t;

endpackage

`default_nettype wire

[rtl/lpcp_if.sv]
// Handshake channel interfaces for the lidar point projection block.
// Depends on lpcp_pkg for field widths.
`default_nettype none

// Input point channel
interface lpcp_point_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lpcp_pkg::PT_W-1:0]     point_x;
  logic signed [lpcp_pkg::PT_W-1:0]     point_y;
  logic signed [lpcp_pkg::PT_W-1:0]     point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

// Output pixel channel
interface lpcp_pixel_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lpcp_pkg::PIX_W-1:0]    pixel_u;
  logic signed [lpcp_pkg::PIX_W-1:0]    pixel_v;
  logic                                 in_front;
  logic                                 clipped;

  modport source (output valid, pixel_u, pixel_v, in_front, clipped, input ready);
  modport sink   (input valid, pixel_u, pixel_v, in_front, clipped, output ready);
endinterface

// Configuration write channel
interface lpcp_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [lpcp_pkg::CFG_IDX_W-1:0]       index;
  logic [lpcp_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/lidar_point_camera_projection.sv]
// Channel   Dir  Payload
// point     in   point_x, point_y, point_z (signed Q7.16)
// pixel     out  pixel_u, pixel_v (signed Q15.8), in_front, clipped
// cfg       in   index (3 bits), data (60 bits); ready is always high
//
// One point per cycle enters while the output buffer is not full; each result passes
// through multiply, sum, focal multiply, 26 divider stages (prep, then one quotient
// bit per stage) and a two-entry output buffer. The divider depth sets the latency.
// The whole pipeline holds while the output buffer is full; point.ready comes from a
// register, not from pixel.ready. Reset (rst, synchronous) empties the pipeline and
// clears all configuration registers to zero.
// Depends on lpcp_pkg, lpcp_if, lpcp_div and the assertion macro header.
`default_nettype none
`include "lidar_point_camera_projection_defines.svh"

module lidar_point_camera_projection (
  input  logic                clk,
  input  logic                rst,
  lpcp_point_if.sink          point,
  lpcp_pixel_if.source        pixel,
  lpcp_cfg_if.sink            cfg
);

  // Configuration registers
  logic [lpcp_pkg::ROW_W-1:0]   rot_row [3];
  logic [lpcp_pkg::TRANS_W-1:0] trans;
  logic [lpcp_pkg::PAIR_W-1:0]  focal;
  logic [lpcp_pkg::PAIR_W-1:0]  principal;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row[0] <= '0;
      rot_row[1] <= '0;
      rot_row[2] <= '0;
      trans      <= '0;
      focal      <= '0;
      principal  <= '0;
    end else if (cfg.valid) begin
      unique case (lpcp_pkg::cfg_idx_t'(cfg.index))
        lpcp_pkg::REG_ROT_ROW0:  rot_row[0] <= cfg.data[lpcp_pkg::ROW_W-1:0];
        lpcp_pkg::REG_ROT_ROW1:  rot_row[1] <= cfg.data[lpcp_pkg::ROW_W-1:0];
        lpcp_pkg::REG_ROT_ROW2:  rot_row[2] <= cfg.data[lpcp_pkg::ROW_W-1:0];
        lpcp_pkg::REG_TRANS:     trans      <= cfg.data[lpcp_pkg::TRANS_W-1:0];
        lpcp_pkg::REG_FOCAL:     focal      <= cfg.data[lpcp_pkg::PAIR_W-1:0];
        lpcp_pkg::REG_PRINCIPAL: principal  <= cfg.data[lpcp_pkg::PAIR_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: hold everything while the output buffer is full
  logic [1:0] cnt;
  logic       en;
  assign en          = (cnt != 2'd2);
  assign point.ready = en;

  // Stage 1: nine rotation products
  logic signed [lpcp_pkg::PT_W-1:0]   pt [3];
  logic signed [lpcp_pkg::PROD_W-1:0] prod [3][3];
  logic                               v1;

  assign pt[0] = point.point_x;
  assign pt[1] = point.point_y;
  assign pt[2] = point.point_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod[r][k] <= $signed(rot_row[r][k*lpcp_pkg::ROT_W +: lpcp_pkg::ROT_W]) * pt[k];
        end
      end
    end
  end

  // Stage 2: sum, shift to Q16, add translation
  logic signed [lpcp_pkg::SUM_W-1:0] sum3 [3];
  logic signed [lpcp_pkg::CAM_W-1:0] cam_next [3];
  logic signed [lpcp_pkg::CAM_W-1:0] cam [3];
  logic                              v2;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum3[r] = lpcp_pkg::SUM_W'(prod[r][0]) + lpcp_pkg::SUM_W'(prod[r][1])
              + lpcp_pkg::SUM_W'(prod[r][2]);
      cam_next[r] = lpcp_pkg::CAM_W'(sum3[r] >>> lpcp_pkg::FRAC_SHIFT)
                  + lpcp_pkg::CAM_W'($signed(trans[r*lpcp_pkg::OFF_W +: lpcp_pkg::OFF_W]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        cam[r] <= cam_next[r];
      end
    end
  end

  // Stage 3: focal products, depth sign
  logic signed [lpcp_pkg::NUM_W:0] num_u;
  logic signed [lpcp_pkg::NUM_W:0] num_v;
  lpcp_pkg::lane_req_t             req_u;
  lpcp_pkg::lane_req_t             req_v;
  logic                            front3;
  logic                            v3;

  assign num_u = $signed({1'b0, focal[lpcp_pkg::FOC_W-1:0]}) * cam[0];
  assign num_v = $signed({1'b0, focal[lpcp_pkg::PAIR_W-1:lpcp_pkg::FOC_W]}) * cam[1];

  always_ff @(posedge clk) begin
    if (en) begin
      req_u.num <= num_u[lpcp_pkg::NUM_W-1:0];
      req_u.den <= cam[2][lpcp_pkg::DEN_W-1:0];
      req_u.c   <= principal[lpcp_pkg::FOC_W-1:0];
      req_v.num <= num_v[lpcp_pkg::NUM_W-1:0];
      req_v.den <= cam[2][lpcp_pkg::DEN_W-1:0];
      req_v.c   <= principal[lpcp_pkg::PAIR_W-1:lpcp_pkg::FOC_W];
      front3    <= (cam[2] > 0);
    end
  end

  // Valid bits through the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= point.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Divider lanes
  lpcp_pkg::lane_res_t res_u;
  lpcp_pkg::lane_res_t res_v;

  lpcp_div u_div_u (.clk(clk), .en(en), .req(req_u), .res(res_u));
  lpcp_div u_div_v (.clk(clk), .en(en), .req(req_v), .res(res_v));

  // Valid and depth flag alongside the divider stages
  logic [lpcp_pkg::DIV_LAT-1:0] vq;
  logic [lpcp_pkg::DIV_LAT-1:0] fq;
  logic                         vlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= '0;
    end else if (en) begin
      vq <= {vq[lpcp_pkg::DIV_LAT-2:0], v3};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fq <= {fq[lpcp_pkg::DIV_LAT-2:0], front3};
    end
  end

  assign vlast = vq[lpcp_pkg::DIV_LAT-1];

  // Assemble the result; zero everything when behind the camera
  lpcp_pkg::pix_item_t push_item;
  logic                front;
  assign front = fq[lpcp_pkg::DIV_LAT-1];

  always_comb begin
    push_item.in_front = front;
    push_item.pixel_u  = front ? res_u.pix : '0;
    push_item.pixel_v  = front ? res_v.pix : '0;
    push_item.clipped  = front & (res_u.clip | res_v.clip);
  end

  // Two-entry output buffer
  lpcp_pkg::pix_item_t buf0;
  lpcp_pkg::pix_item_t buf1;
  logic                push;
  logic                pop;
  logic [1:0]          cnt_next;

  assign push = en & vlast;
  assign pop  = pixel.valid & pixel.ready;

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_next = cnt + 2'd1;
      2'b01:   cnt_next = cnt - 2'd1;
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      buf0 <= (cnt == 2'd2) ? buf1 : push_item;
    end else if (push && cnt == 2'd0) begin
      buf0 <= push_item;
    end
    if (push && !pop && cnt == 2'd1) begin
      buf1 <= push_item;
    end
  end

  assign pixel.valid    = (cnt != 2'd0);
  assign pixel.pixel_u  = buf0.pixel_u;
  assign pixel.pixel_v  = buf0.pixel_v;
  assign pixel.in_front = buf0.in_front;
  assign pixel.clipped  = buf0.clipped;

  // Checks
  logic out_behind;
  logic out_clipped;
  logic behind_zero;
  logic clip_at_limit;

  assign out_behind    = pixel.valid && !pixel.in_front;
  assign out_clipped   = pixel.valid && pixel.clipped;
  assign behind_zero   = (pixel.pixel_u == '0) && (pixel.pixel_v == '0) && !pixel.clipped;
  assign clip_at_limit = (pixel.pixel_u == lpcp_pkg::PIX_MAX)
                      || (pixel.pixel_u == lpcp_pkg::PIX_MIN)
                      || (pixel.pixel_v == lpcp_pkg::PIX_MAX)
                      || (pixel.pixel_v == lpcp_pkg::PIX_MIN);

  `LPCP_ASSERT_SAME(a_cnt_range, 1'b1, cnt != 2'd3, "output buffer count out of range")
  `LPCP_ASSERT_NEXT(a_stall_hold, !en, vlast == $past(vlast), "stalled pipeline lost an item")
  `LPCP_ASSERT_SAME(a_behind_zero, out_behind, behind_zero, "behind-camera result not zero")
  `LPCP_ASSERT_SAME(a_clip_limit, out_clipped, clip_at_limit, "clipped result not at a limit")

endmodule

`default_nettype wire

[rtl/lpcp_div.sv]
// One projection lane: pipelined signed divide of f*coord by depth, plus center.
// Restoring division, one quotient bit per stage. Depends on lpcp_pkg.
`default_nettype none

module lpcp_div (
  input  logic                clk,
  input  logic                en,
  input  lpcp_pkg::lane_req_t req,
  output lpcp_pkg::lane_res_t res
);

  typedef struct packed {
    logic [lpcp_pkg::DEN_W-1:0] rem;
    logic [lpcp_pkg::QB-1:0]    lo;
    logic [lpcp_pkg::QB-1:0]    q;
    logic [lpcp_pkg::DEN_W-1:0] den;
    logic [lpcp_pkg::FOC_W-1:0] c;
    logic                       neg;
    logic                       ovf;
  } div_stage_t;

  // One restoring step: bring down the next numerator bit, subtract if it fits
  function automatic div_stage_t div_step(input div_stage_t s);
    logic [lpcp_pkg::DEN_W:0] trial;
    logic [lpcp_pkg::DEN_W:0] diff;
    div_stage_t               o;
    trial = {s.rem, s.lo[lpcp_pkg::QB-1]};
    diff  = trial - {1'b0, s.den};
    o     = s;
    o.lo  = {s.lo[lpcp_pkg::QB-2:0], 1'b0};
    if (trial >= {1'b0, s.den}) begin
      o.rem = diff[lpcp_pkg::DEN_W-1:0];
      o.q   = {s.q[lpcp_pkg::QB-2:0], 1'b1};
    end else begin
      o.rem = trial[lpcp_pkg::DEN_W-1:0];
      o.q   = {s.q[lpcp_pkg::QB-2:0], 1'b0};
    end
    return o;
  endfunction

  div_stage_t                   st [lpcp_pkg::QB+1];
  logic signed [lpcp_pkg::NUM_W-1:0] abs_num;
  logic [lpcp_pkg::MAG_W-1:0]   mag;
  logic [lpcp_pkg::MAG_W-lpcp_pkg::QB-1:0] mag_hi;
  div_stage_t                   prep;

  // Prepare: magnitude, sign and quotient overflow (q would need more than QB bits)
  assign abs_num = req.num[lpcp_pkg::NUM_W-1] ? -req.num : req.num;
  assign mag     = abs_num[lpcp_pkg::MAG_W-1:0];
  assign mag_hi  = mag[lpcp_pkg::MAG_W-1:lpcp_pkg::QB];

  always_comb begin
    prep.rem = lpcp_pkg::DEN_W'(mag_hi);
    prep.lo  = mag[lpcp_pkg::QB-1:0];
    prep.q   = '0;
    prep.den = req.den;
    prep.c   = req.c;
    prep.neg = req.num[lpcp_pkg::NUM_W-1];
    prep.ovf = (lpcp_pkg::DEN_W'(mag_hi) >= req.den);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= prep;
    end
  end

  // Division stages, one quotient bit each
  for (genvar i = 0; i < lpcp_pkg::QB; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1] <= div_step(st[i]);
      end
    end
  end

  // Apply sign, add center, saturate
  div_stage_t                        last;
  logic signed [lpcp_pkg::RES_W-1:0] q_ext;
  logic signed [lpcp_pkg::RES_W-1:0] sum;

  assign last  = st[lpcp_pkg::QB];
  assign q_ext = $signed({2'b00, last.q});
  assign sum   = (last.neg ? -q_ext : q_ext)
               + $signed({{(lpcp_pkg::RES_W-lpcp_pkg::FOC_W){1'b0}}, last.c});

  always_comb begin
    priority if (last.ovf) begin
      res.pix  = last.neg ? lpcp_pkg::PIX_MIN : lpcp_pkg::PIX_MAX;
      res.clip = 1'b1;
    end else if (sum > lpcp_pkg::RES_W'(lpcp_pkg::PIX_MAX)) begin
      res.pix  = lpcp_pkg::PIX_MAX;
      res.clip = 1'b1;
    end else if (sum < lpcp_pkg::RES_W'(lpcp_pkg::PIX_MIN)) begin
      res.pix  = lpcp_pkg::PIX_MIN;
      res.clip = 1'b1;
    end else begin
      res.pix  = sum[lpcp_pkg::PIX_W-1:0];
      res.clip = 1'b0;
    end
  end

endmodule

`default_nettype wire

[bench/lpcp_projection_checker.sv]
// Scoreboard for the lidar point camera projection block: mirrors the register
// writes, computes the pixel expected for each accepted point and compares results.
// Depends on lpcp_pkg and the channel interfaces in lpcp_if.

module lpcp_projection_checker
  import lpcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  lpcp_point_if       point,
  lpcp_pixel_if       pixel,
  lpcp_cfg_if         cfg,
  output int unsigned outstanding,
  output int unsigned fail_count
);

  // Shadow copy of the calibration registers
  logic [ROW_W-1:0]   rot_row [3];
  logic [TRANS_W-1:0] trans_vec;
  logic [PAIR_W-1:0]  focal_pair;
  logic [PAIR_W-1:0]  center_pair;

  pix_item_t   pending_pixels [$];
  int unsigned fault_count;

  // Rotate one axis and add its offset; exact at Q16 after the floor shift
  function automatic longint cam_axis(input logic [ROW_W-1:0] row,
                                      input logic signed [PT_W-1:0] px, py, pz,
                                      input logic signed [OFF_W-1:0] off);
    logic signed [ROT_W-1:0] r0, r1, r2;
    longint acc;
    r0 = row[ROT_W-1:0];
    r1 = row[2*ROT_W-1:ROT_W];
    r2 = row[3*ROT_W-1:2*ROT_W];
    acc = longint'(r0) * longint'(px) + longint'(r1) * longint'(py)
        + longint'(r2) * longint'(pz);
    return (acc >>> FRAC_SHIFT) + longint'(off);
  endfunction

  // Scale by focal length, divide by depth (truncating), shift by center, clamp
  function automatic lane_res_t scale_axis(input logic [FOC_W-1:0] f, input longint num,
                                           input longint depth,
                                           input logic [FOC_W-1:0] c);
    longint    q;
    lane_res_t res;
    q = (longint'(f) * num) / depth + longint'(c);
    res.clip = 1'b0;
    if (q > longint'(PIX_MAX)) begin
      res.pix  = PIX_MAX;
      res.clip = 1'b1;
    end else if (q < longint'(PIX_MIN)) begin
      res.pix  = PIX_MIN;
      res.clip = 1'b1;
    end else begin
      res.pix = q[PIX_W-1:0];
    end
    return res;
  endfunction

  // Full projection of one lidar point with the current calibration
  function automatic pix_item_t project_point(input logic signed [PT_W-1:0] px, py, pz);
    longint    cam_x, cam_y, cam_z;
    lane_res_t lane_u, lane_v;
    pix_item_t item;
    cam_x = cam_axis(rot_row[0], px, py, pz, trans_vec[OFF_W-1:0]);
    cam_y = cam_axis(rot_row[1], px, py, pz, trans_vec[2*OFF_W-1:OFF_W]);
    cam_z = cam_axis(rot_row[2], px, py, pz, trans_vec[3*OFF_W-1:2*OFF_W]);
    item = '0;
    // Points at or behind the image plane give an all-zero item
    if (cam_z > 0) begin
      lane_u = scale_axis(focal_pair[FOC_W-1:0], cam_x, cam_z, center_pair[FOC_W-1:0]);
      lane_v = scale_axis(focal_pair[PAIR_W-1:FOC_W], cam_y, cam_z,
                          center_pair[PAIR_W-1:FOC_W]);
      item.pixel_u  = lane_u.pix;
      item.pixel_v  = lane_v.pix;
      item.in_front = 1'b1;
      item.clipped  = lane_u.clip | lane_v.clip;
    end
    return item;
  endfunction

  // Count a failure, print only the first few
  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    pix_item_t got;
    pix_item_t want;
    if (rst) begin
      rot_row     <= '{default: '0};
      trans_vec   <= '0;
      focal_pair  <= '0;
      center_pair <= '0;
      pending_pixels.delete();
      fault_count = 0;
      outstanding <= 0;
      fail_count  <= 0;
    end else begin
      // Mirror register writes; drop unknown indexes
      if (cfg.valid && cfg.ready) begin
        case (cfg_idx_t'(cfg.index))
          REG_ROT_ROW0:  rot_row[0]  <= cfg.data[ROW_W-1:0];
          REG_ROT_ROW1:  rot_row[1]  <= cfg.data[ROW_W-1:0];
          REG_ROT_ROW2:  rot_row[2]  <= cfg.data[ROW_W-1:0];
          REG_TRANS:     trans_vec   <= cfg.data[TRANS_W-1:0];
          REG_FOCAL:     focal_pair  <= cfg.data[PAIR_W-1:0];
          REG_PRINCIPAL: center_pair <= cfg.data[PAIR_W-1:0];
          default: ;
        endcase
      end
      // Check each delivered item against the oldest expectation
      if (pixel.valid && pixel.ready) begin
        got = {pixel.pixel_u, pixel.pixel_v, pixel.in_front, pixel.clipped};
        if (pending_pixels.size() == 0) begin
          report_fault($sformatf("unexpected pixel item: u=%0d v=%0d front=%0b clip=%0b",
                                 got.pixel_u, got.pixel_v, got.in_front, got.clipped));
        end else begin
          want = pending_pixels.pop_front();
          if (got.pixel_u !== want.pixel_u || got.pixel_v !== want.pixel_v ||
              got.in_front !== want.in_front || got.clipped !== want.clipped) begin
            report_fault($sformatf({"pixel mismatch: expected u=%0d v=%0d front=%0b clip=%0b,",
                                    " got u=%0d v=%0d front=%0b clip=%0b"},
                                   want.pixel_u, want.pixel_v, want.in_front, want.clipped,
                                   got.pixel_u, got.pixel_v, got.in_front, got.clipped));
          end
        end
      end
      // Queue the expected pixel for each accepted point
      if (point.valid && point.ready)
        pending_pixels.push_back(project_point(point.point_x, point.point_y, point.point_z));
      outstanding <= pending_pixels.size();
      fail_count  <= fault_count;
    end
  end

endmodule

[bench/tb.sv]
// Top of the lidar point camera projection bench: clock, reset, calibration
// writes, point stimulus with random gaps and output stalls, and the verdict.
// Depends on lpcp_pkg, lpcp_if, the block itself and lpcp_projection_checker.

module tb;
  import lpcp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int ONE_METER    = 65536;   // Q16
  localparam int ROT_ONE      = 16384;   // Q2.14
  localparam int PIX_ONE      = 256;     // Q12.8
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 170;
  localparam int DRAIN_CYCLES = 40;

  localparam logic signed [PT_W-1:0] PT_MAX = {1'b0, {(PT_W-1){1'b1}}};
  localparam logic signed [PT_W-1:0] PT_MIN = {1'b1, {(PT_W-1){1'b0}}};

  localparam logic [ROT_W-1:0] ROT_CORNER [5] = '{16'h7FFF, 16'h8000, 16'h0000,
                                                  16'h4000, 16'hC000};
  localparam logic [OFF_W-1:0] OFF_CORNER [3] = '{20'h7FFFF, 20'h80000, 20'h00000};
  localparam logic [FOC_W-1:0] FOC_CORNER [3] = '{20'hFFFFF, 20'h00000, 20'h00001};

  typedef enum {SET_VIEW, SET_NOISE, SET_EXTREME} cam_setup_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  bit          quiet_tail = 1'b0;
  int unsigned ready_hold = 0;
  int unsigned outstanding;
  int unsigned fail_count;

  lpcp_point_if point_ch ();
  lpcp_pixel_if pixel_ch ();
  lpcp_cfg_if   cfg_ch ();

  lidar_point_camera_projection dut (
    .clk   (clk),
    .rst   (rst),
    .point (point_ch),
    .pixel (pixel_ch),
    .cfg   (cfg_ch)
  );

  lpcp_projection_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .point       (point_ch),
    .pixel       (pixel_ch),
    .cfg         (cfg_ch),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("** lidar_point_camera_projection: FAILED **");
    $finish;
  end

  // Stall the pixel side in random bursts; hold ready high in the tail
  always @(posedge clk) begin
    if (rst || quiet_tail) begin
      pixel_ch.ready <= 1'b1;
      ready_hold     <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (pixel_ch.ready) begin
      if ($urandom_range(0, 5) == 0) begin
        pixel_ch.ready <= 1'b0;
        ready_hold     <= $urandom_range(0, 11);
      end else begin
        ready_hold <= $urandom_range(0, 15);
      end
    end else begin
      pixel_ch.ready <= 1'b1;
      ready_hold     <= $urandom_range(0, 20);
    end
  end

  function automatic int sym_rand(input int unsigned span);
    return int'($urandom_range(0, 2 * span)) - int'(span);
  endfunction

  // Offer one point and hold it until taken; valid stays high afterwards
  task automatic push_point(input logic signed [PT_W-1:0] x, y, z);
    point_ch.valid   <= 1'b1;
    point_ch.point_x <= x;
    point_ch.point_y <= y;
    point_ch.point_z <= z;
    do @(posedge clk); while (!point_ch.ready);
  endtask

  // Write one register; valid stays high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic apply_setup(input logic [CFG_DATA_W-1:0] row0, row1, row2,
                             input logic [CFG_DATA_W-1:0] trans, focal, center);
    write_reg(REG_ROT_ROW0, row0);
    write_reg(REG_ROT_ROW1, row1);
    write_reg(REG_ROT_ROW2, row2);
    write_reg(REG_TRANS, trans);
    write_reg(REG_FOCAL, focal);
    write_reg(REG_PRINCIPAL, center);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending and hold until every expected pixel has been delivered
  task automatic wait_for_results();
    point_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0]   row_val [3];
    logic [CFG_DATA_W-1:0]   trans_val, focal_val, center_val;
    logic signed [PT_W-1:0]  px, py, pz;
    cam_setup_t              mode;
    int                      axis [3];
    int                      tmp, j, entry, sel;

    point_ch.valid   <= 1'b0;
    point_ch.point_x <= '0;
    point_ch.point_y <= '0;
    point_ch.point_z <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_ROT_ROW0;
    cfg_ch.data      <= '0;
    rst              <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset calibration: depth is always zero, so nothing is in front
    push_point(PT_MAX, PT_MIN, PT_MAX);
    push_point('0, '0, '0);
    wait_for_results();

    // Identity pose, 500 px focal length, 640x480 center
    apply_setup(CFG_DATA_W'({32'd0, 16'(ROT_ONE)}),
                CFG_DATA_W'({16'd0, 16'(ROT_ONE), 16'd0}),
                CFG_DATA_W'({16'(ROT_ONE), 32'd0}), '0,
                CFG_DATA_W'({20'(500 * PIX_ONE), 20'(500 * PIX_ONE)}),
                CFG_DATA_W'({20'(240 * PIX_ONE), 20'(320 * PIX_ONE)}));
    push_point('0, '0, 24'(ONE_METER));
    push_point(24'(ONE_METER), 24'(-ONE_METER), 24'(2 * ONE_METER));
    push_point(PT_MAX, PT_MAX, PT_MAX);
    push_point(PT_MIN, PT_MIN, 24'sd1);            // saturate low on both axes
    push_point(PT_MAX, PT_MIN, 24'sd1);            // saturate high on u, low on v
    push_point(24'(5 * ONE_METER), '0, '0);        // depth exactly zero
    push_point(24'(5 * ONE_METER), 24'(5 * ONE_METER), 24'(-ONE_METER));
    push_point('0, '0, PT_MIN);
    push_point(PT_MIN, PT_MAX, PT_MAX);
    wait_for_results();

    // Unknown register indexes must leave the calibration alone
    write_reg(REG_SPARE_LO, {CFG_DATA_W{1'b1}});
    write_reg(REG_SPARE_HI, CFG_DATA_W'({$urandom, $urandom}));
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    push_point(24'(ONE_METER), 24'(ONE_METER), 24'(3 * ONE_METER));
    wait_for_results();

    // Every register at its extreme
    apply_setup(CFG_DATA_W'({3{16'h7FFF}}), CFG_DATA_W'({3{16'h8000}}),
                CFG_DATA_W'({3{16'h7FFF}}),
                {20'h7FFFF, 20'h7FFFF, 20'h80000},
                CFG_DATA_W'({20'hFFFFF, 20'hFFFFF}), CFG_DATA_W'({20'hFFFFF, 20'hFFFFF}));
    push_point(PT_MAX, PT_MAX, PT_MAX);
    push_point(PT_MIN, PT_MIN, PT_MIN);
    push_point('0, '0, '0);
    push_point(PT_MAX, '0, PT_MIN);
    push_point(24'sd1, -24'sd1, 24'sd1);
    wait_for_results();

    // Zero focal lengths and center
    write_reg(REG_FOCAL, '0);
    write_reg(REG_PRINCIPAL, '0);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    push_point(24'(ONE_METER), 24'(-ONE_METER), 24'(ONE_METER));
    push_point(PT_MAX, PT_MIN, PT_MAX);
    wait_for_results();

    // Random phases, each with its own calibration
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1 || p % 4 == 0 || p % 4 == 2) mode = SET_VIEW;
      else if (p % 4 == 1) mode = SET_NOISE;
      else mode = SET_EXTREME;

      case (mode)
        SET_VIEW: begin
          // Signed axis permutation with a little tilt, as a real mount
          axis = '{0, 1, 2};
          for (int k = 2; k > 0; k--) begin
            j       = $urandom_range(0, k);
            tmp     = axis[k];
            axis[k] = axis[j];
            axis[j] = tmp;
          end
          for (int r = 0; r < 3; r++) begin
            row_val[r] = '0;
            for (int c = 0; c < 3; c++) begin
              entry = sym_rand(300);
              if (c == axis[r]) entry += $urandom_range(0, 1) ? ROT_ONE : -ROT_ONE;
              row_val[r][ROT_W*c +: ROT_W] = entry[ROT_W-1:0];
            end
          end
          trans_val = '0;
          for (int k = 0; k < 3; k++) begin
            entry = sym_rand(3 * ONE_METER / 2);
            trans_val[OFF_W*k +: OFF_W] = entry[OFF_W-1:0];
          end
          focal_val  = CFG_DATA_W'({20'($urandom_range(200 * PIX_ONE, 1500 * PIX_ONE)),
                                    20'($urandom_range(200 * PIX_ONE, 1500 * PIX_ONE))});
          center_val = CFG_DATA_W'({20'($urandom_range(100 * PIX_ONE, 1000 * PIX_ONE)),
                                    20'($urandom_range(100 * PIX_ONE, 1000 * PIX_ONE))});
        end
        SET_NOISE: begin
          for (int r = 0; r < 3; r++) row_val[r] = CFG_DATA_W'({$urandom, $urandom});
          trans_val  = CFG_DATA_W'({$urandom, $urandom});
          focal_val  = CFG_DATA_W'({$urandom, $urandom});
          center_val = CFG_DATA_W'({$urandom, $urandom});
        end
        default: begin
          trans_val = '0;
          for (int r = 0; r < 3; r++) begin
            row_val[r] = '0;
            for (int c = 0; c < 3; c++)
              row_val[r][ROT_W*c +: ROT_W] = ROT_CORNER[$urandom_range(0, 4)];
            trans_val[OFF_W*r +: OFF_W] = OFF_CORNER[$urandom_range(0, 2)];
          end
          focal_val  = CFG_DATA_W'({FOC_CORNER[$urandom_range(0, 2)],
                                    FOC_CORNER[$urandom_range(0, 2)]});
          center_val = CFG_DATA_W'({FOC_CORNER[$urandom_range(0, 2)],
                                    FOC_CORNER[$urandom_range(0, 2)]});
        end
      endcase
      apply_setup(row_val[0], row_val[1], row_val[2], trans_val, focal_val, center_val);

      if (p == PHASES - 1) quiet_tail <= 1'b1;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Idle the point side now and then, except in the tail
        if (p != PHASES - 1 && $urandom_range(0, 4) == 0) begin
          point_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
          px = 24'(sym_rand(40 * ONE_METER));
          py = 24'(sym_rand(40 * ONE_METER));
          pz = 24'(sym_rand(40 * ONE_METER));
        end else if (sel < 9) begin
          px = 24'($urandom);
          py = 24'($urandom);
          pz = 24'($urandom);
        end else begin
          // Near the origin: tiny depths push the pixels to saturation
          px = 24'(sym_rand(512));
          py = 24'(sym_rand(512));
          pz = 24'(sym_rand(512));
        end
        push_point(px, py, pz);
      end
      wait_for_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("** lidar_point_camera_projection: PASSED **");
    else
      $display("** lidar_point_camera_projection: FAILED **");
    $finish;
  end

endmodule
